>>> design/fskd_pkg.sv
// Shared types, constants and record assembly for the FSK run deframer.
package fskd_pkg;

	localparam int SYNC_LEN    = 20;
	localparam int FRAME_LEN   = 90;
	localparam int PAYLOAD_LEN = FRAME_LEN - SYNC_LEN;
	localparam int CELL_BITS   = 10;
	localparam int POS_W       = $clog2(PAYLOAD_LEN);
	localparam int FILL_W      = $clog2(SYNC_LEN + 1);
	localparam int SPB_W       = 8;
	localparam int SAMP_W      = 16;
	localparam int CELLS_W     = SAMP_W + 1;

	localparam logic [SYNC_LEN-1:0] SYNC_PATTERN = 20'b00000000010111111111;
	localparam logic [SPB_W-1:0]    SPB_RESET    = 8'd20;

	typedef struct packed {
		logic              run_level;
		logic [SAMP_W-1:0] run_samples;
	} run_t;

	typedef struct packed {
		logic [7:0]  record_id;
		logic [31:0] record_value;
		logic [15:0] computed_check;
		logic        check_ok;
	} rec_t;

	typedef struct packed {
		logic step;
		logic level;
	} eng_ctl_t;

	typedef struct packed {
		logic frame_done;
	} eng_sts_t;

	// oldest payload bit sits in the top bit of the vector
	function automatic logic [7:0] frame_byte(input logic [PAYLOAD_LEN-1:0] bits,
		input int j);
		logic [7:0] v;
		v = '0;
		for (int i = 0; i < 8; i++) begin
			v[i] = bits[PAYLOAD_LEN-1-(j*CELL_BITS+1+i)];
		end
		return v;
	endfunction

	function automatic rec_t make_record(input logic [PAYLOAD_LEN-1:0] bits);
		logic [7:0] b [7];
		logic [7:0] s1;
		logic [7:0] s2;
		rec_t r;
		for (int j = 0; j < 7; j++) begin
			b[j] = frame_byte(bits, j);
		end
		s1 = b[0] + b[1] + b[2] + b[3] + b[4];
		s2 = {b[0][5:0], 2'b00} + b[0] + {b[1][5:0], 2'b00} + {b[2][6:0], 1'b0} + b[2]
			+ {b[3][6:0], 1'b0} + b[4];
		r.record_id      = b[0];
		r.record_value   = {b[1], b[2], b[3], b[4]};
		r.computed_check = {s1, ~s2};
		r.check_ok       = ({s1, ~s2} == {b[5], b[6]});
		return r;
	endfunction

endpackage

>>> design/fskd_div.sv
// Restoring divider, one quotient bit per cycle, yields the cell count of a run.
module fskd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fskd_pkg::CELLS_W-1:0]   dividend,
	input  logic [fskd_pkg::SPB_W-1:0]     divisor,
	output logic                           done,
	output logic [fskd_pkg::CELLS_W-1:0]   quotient
);
	import fskd_pkg::*;

	localparam int CNT_W = $clog2(CELLS_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CELLS_W-1:0] num_q;
	logic [CELLS_W-1:0] quo_q;
	logic [SPB_W-1:0]   rem_q;
	logic [SPB_W-1:0]   dsr_q;
	logic [SPB_W:0]     trial;
	logic               ge;
	logic [SPB_W:0]     diff;

	assign trial = {rem_q, num_q[CELLS_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CELLS_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[CELLS_W-2:0], 1'b0};
			rem_q <= ge ? diff[SPB_W-1:0] : trial[SPB_W-1:0];
			quo_q <= {quo_q[CELLS_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> design/fskd_eng.sv
// Per-cell engine: sync history, lock detection and payload collection.
module fskd_eng (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fskd_pkg::eng_ctl_t                 ctl,
	output fskd_pkg::eng_sts_t                 sts,
	output logic [fskd_pkg::PAYLOAD_LEN-1:0]   payload_next
);
	import fskd_pkg::*;

	logic [SYNC_LEN-1:0]    hist_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   locked_q;
	logic [POS_W-1:0]       pos_q;
	logic [PAYLOAD_LEN-1:0] sr_q;
	logic [SYNC_LEN-1:0]    hist_n;
	logic [FILL_W-1:0]      fill_n;
	logic                   match;
	logic                   last_bit;

	assign hist_n   = {hist_q[SYNC_LEN-2:0], ctl.level};
	assign fill_n   = (fill_q < FILL_W'(SYNC_LEN)) ? fill_q + 1'b1 : fill_q;
	assign match    = (fill_n >= FILL_W'(SYNC_LEN - 1))
		&& (hist_n[SYNC_LEN-2:0] == SYNC_PATTERN[SYNC_LEN-2:0]);
	assign last_bit = (pos_q == POS_W'(PAYLOAD_LEN - 1));

	assign payload_next   = {sr_q[PAYLOAD_LEN-2:0], ctl.level};
	assign sts.frame_done = ctl.step && locked_q && last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '0;
			fill_q   <= '0;
			locked_q <= 1'b0;
			pos_q    <= '0;
		end else if (ctl.step) begin
			hist_q <= hist_n;
			fill_q <= fill_n;
			if (!locked_q) begin
				if (match) begin
					locked_q <= 1'b1;
					pos_q    <= '0;
				end
			end else if (last_bit) begin
				locked_q <= 1'b0;
				pos_q    <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && locked_q) begin
			sr_q <= payload_next;
		end
	end
endmodule

>>> design/fsk_run_deframer_8n1.sv
// Top level of the FSK run deframer: sequencer, cell register and result register.
//
//  channel  signals                      moves
//  run      run_valid/run_ready/run      one level run (run_level, run_samples)
//  rec      rec_valid/rec_ready/rec      one decoded record
//  cfg      cfg_valid/cfg_ready/cfg_data cell length in samples, always ready
//
// After the accepting edge a run holds ready low through the serial divider, the cell
// loop at one cycle per bit cell and the closing state.
// A zero cell register accepts the run with no effect.
// Reset clears history and lock and sets the cell length to 20 samples; no clearing pass.
// A record waits in its output register while the next run is worked on; only a
// second finished frame stalls, in the closing cycle, until the record is taken.
module fsk_run_deframer_8n1 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            run_valid,
	output logic                            run_ready,
	input  fskd_pkg::run_t                  run,
	output logic                            rec_valid,
	input  logic                            rec_ready,
	output fskd_pkg::rec_t                  rec,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fskd_pkg::SPB_W-1:0]      cfg_data
);
	import fskd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_CELLS,
		S_FINISH
	} state_t;

	state_t                 state_q;
	logic [SPB_W-1:0]       spb_q;
	logic [CELLS_W-1:0]     cells_q;
	logic                   level_q;
	logic                   pending_q;
	logic                   rec_valid_q;
	logic [PAYLOAD_LEN-1:0] snap_q;
	rec_t                   rec_q;

	logic                   run_acc;
	logic                   div_start;
	logic [CELLS_W-1:0]     dividend;
	logic                   div_done;
	logic [CELLS_W-1:0]     quotient;
	eng_ctl_t               eng_ctl;
	eng_sts_t               eng_sts;
	logic [PAYLOAD_LEN-1:0] payload_next;
	logic                   capture;
	logic                   load;

	assign run_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign run_acc   = run_valid && run_ready;
	assign div_start = run_acc && (spb_q != '0);
	assign dividend  = {1'b0, run.run_samples} + CELLS_W'(spb_q >> 1);

	assign eng_ctl.step  = (state_q == S_CELLS);
	assign eng_ctl.level = level_q;
	assign capture       = eng_sts.frame_done && !pending_q;
	assign load          = (state_q == S_FINISH) && pending_q && (!rec_valid_q || rec_ready);

	fskd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (spb_q),
		.done     (div_done),
		.quotient (quotient)
	);

	fskd_eng u_eng (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (eng_ctl),
		.sts          (eng_sts),
		.payload_next (payload_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			spb_q       <= SPB_RESET;
			cells_q     <= '0;
			level_q     <= 1'b0;
			pending_q   <= 1'b0;
			rec_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				spb_q <= cfg_data;
			end
			if (load) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (div_start) begin
						level_q <= run.run_level;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cells_q <= quotient;
						state_q <= (quotient == '0) ? S_FINISH : S_CELLS;
					end
				end
				S_CELLS: begin
					if (capture) begin
						pending_q <= 1'b1;
					end
					cells_q <= cells_q - 1'b1;
					if (cells_q == CELLS_W'(1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!pending_q) begin
						state_q <= S_IDLE;
					end else if (load) begin
						pending_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			snap_q <= payload_next;
		end
		if (load) begin
			rec_q <= make_record(snap_q);
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;
endmodule

>>> bench/tb_top.sv
// Testbench for fsk_run_deframer_8n1: level runs in, 8N1 records checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import fskd_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             run_valid = 1'b0;
	logic             run_ready;
	run_t             run       = '0;
	logic             rec_valid;
	logic             rec_ready = 1'b0;
	rec_t             rec;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SPB_W-1:0] cfg_data  = '0;

	fsk_run_deframer_8n1 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// deframer state as predicted; payload bit 0 is the oldest collected bit
	logic [SPB_W-1:0]       spb_cur   = SPB_RESET;
	logic [SYNC_LEN-1:0]    sync_hist = '0;
	int unsigned            hist_fill = 0;
	bit                     locked    = 1'b0;
	int unsigned            frame_pos = 0;
	logic [PAYLOAD_LEN-1:0] payload   = '0;
	rec_t                   rec_expected [$];

	int unsigned last_cells   = 0;
	int unsigned items_done   = 0;
	int unsigned fails        = 0;
	int unsigned tx_gap_pct   = 12;
	int unsigned rx_stall_pct = 45;
	int unsigned hold_req     = 0;
	int unsigned hold_left    = 0;

	// byte 0 of fb is frame byte zero, the record id
	function automatic logic [15:0] check_word(input logic [6:0][7:0] fb);
		logic [31:0] s1;
		logic [31:0] s2;
		s1 = 0;
		s2 = 0;
		for (int k = 0; k < 5; k++) begin
			s1 += 32'(fb[k]);
			s2 += (5 - k) * 32'(fb[k]);
		end
		return {s1[7:0], ~s2[7:0]};
	endfunction

	function automatic int unsigned predict_run(input run_t r);
		int unsigned cells;
		int unsigned div;
		logic [6:0][7:0] fb;
		rec_t e;
		bit produced;
		produced = 1'b0;
		last_cells = 0;
		div = 32'(spb_cur);
		if (div == 0) return 0;
		cells = 32'(r.run_samples);
		cells = (cells + div / 2) / div;
		for (int unsigned c = 0; c < cells; c++) begin
			sync_hist = {sync_hist[SYNC_LEN-2:0], r.run_level};
			if (hist_fill < SYNC_LEN) hist_fill++;
			if (!locked) begin
				if (hist_fill >= SYNC_LEN - 1 &&
					sync_hist[SYNC_LEN-2:0] == SYNC_PATTERN[SYNC_LEN-2:0]) begin
					locked = 1'b1;
					frame_pos = SYNC_LEN;
				end
			end else begin
				payload[frame_pos - SYNC_LEN] = r.run_level;
				frame_pos++;
				if (frame_pos >= FRAME_LEN) begin
					if (!produced) begin
						for (int k = 0; k < 7; k++) begin
							for (int i = 0; i < 8; i++) begin
								fb[k][i] = payload[k * CELL_BITS + 1 + i];
							end
						end
						e.record_id      = fb[0];
						e.record_value   = {fb[1], fb[2], fb[3], fb[4]};
						e.computed_check = check_word(fb);
						e.check_ok       = (e.computed_check == {fb[5], fb[6]});
						rec_expected.push_back(e);
						produced = 1'b1;
					end
					frame_pos = 0;
					locked = 1'b0;
				end
			end
		end
		last_cells = cells;
		return cells;
	endfunction

	// sample count that rounds to n cells at the current setting
	function automatic logic [15:0] run_len(input int unsigned n);
		int unsigned half;
		int unsigned lo;
		int unsigned hi;
		if (spb_cur == 0) return 16'($urandom_range(65535));
		half = spb_cur / 2;
		lo = (n == 0) ? 0 : n * spb_cur - half;
		hi = (n + 1) * spb_cur - half - 1;
		if (hi > 65535) hi = 65535;
		return 16'($urandom_range(hi, lo));
	endfunction

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			rec_ready = 1'b0;
			hold_left--;
		end else begin
			rec_ready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : rec_check
		rec_t e;
		if (arst_n && rec_valid && rec_ready) begin
			if (rec_expected.size() == 0) begin
				$error("record_id: expected none, got %0h", rec.record_id);
				fails++;
			end else begin
				e = rec_expected.pop_front();
				if (rec.record_id !== e.record_id) begin
					$error("record_id: expected %0h, got %0h", e.record_id, rec.record_id);
					fails++;
				end
				if (rec.record_value !== e.record_value) begin
					$error("record_value: expected %0h, got %0h",
						e.record_value, rec.record_value);
					fails++;
				end
				if (rec.computed_check !== e.computed_check) begin
					$error("computed_check: expected %0h, got %0h",
						e.computed_check, rec.computed_check);
					fails++;
				end
				if (rec.check_ok !== e.check_ok) begin
					$error("check_ok: expected %0b, got %0b", e.check_ok, rec.check_ok);
					fails++;
				end
			end
		end
	end

	task automatic send_run(input logic level, input logic [15:0] samples);
		run_t item;
		item.run_level   = level;
		item.run_samples = samples;
		if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			run_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		run = item;
		run_valid = 1'b1;
		@(posedge clk);
		while (!run_ready) @(posedge clk);
		if (predict_run(item) != 0) items_done++;
		@(negedge clk);
		run_valid = 1'b0;
	endtask

	task automatic wait_drain();
		while (rec_expected.size() != 0) @(negedge clk);
	endtask

	// runs that end without a record may still be in the cell loop
	task automatic settle();
		wait_drain();
		repeat (last_cells + 40) @(negedge clk);
	endtask

	task automatic write_spb(input logic [SPB_W-1:0] v);
		settle();
		cfg_data = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		spb_cur = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// idle ones, sync word, then seven 8N1 cells
	task automatic send_frame(input logic [6:0][7:0] fb, input bit broken);
		bit lv [$];
		bit cur;
		int unsigned n;
		repeat ($urandom_range(0, 5)) lv.push_back(1'b1);
		repeat ($urandom_range(8, 12)) lv.push_back(1'b0);
		lv.push_back(1'b1);
		lv.push_back(1'b0);
		repeat (9) lv.push_back(1'b1);
		for (int k = 0; k < 7; k++) begin
			lv.push_back(broken ? 1'($urandom_range(1)) : 1'b0);
			for (int i = 0; i < 8; i++) lv.push_back(fb[k][i]);
			lv.push_back(broken ? 1'($urandom_range(1)) : 1'b1);
		end
		cur = lv[0];
		n = 0;
		foreach (lv[i]) begin
			if (lv[i] == cur) begin
				n++;
			end else begin
				send_run(cur, run_len(n));
				cur = lv[i];
				n = 1;
			end
		end
		send_run(cur, run_len(n));
	endtask

	task automatic send_random_frame();
		logic [6:0][7:0] fb;
		int unsigned pick;
		for (int k = 0; k < 7; k++) begin
			pick = $urandom_range(99);
			if (pick < 10) fb[k] = 8'h00;
			else if (pick < 20) fb[k] = 8'hFF;
			else fb[k] = 8'($urandom);
		end
		if ($urandom_range(99) < 65) {fb[5], fb[6]} = check_word(fb);
		send_frame(fb, $urandom_range(99) < 10);
	endtask

	// sync pattern complete before 19 bits have entered: no lock
	task automatic test_short_history();
		send_run(1'b1, run_len(1));
		send_run(1'b0, run_len(1));
		send_run(1'b1, run_len(9));
	endtask

	task automatic test_check_ok_frame();
		logic [6:0][7:0] fb;
		fb = '0;
		{fb[5], fb[6]} = check_word(fb);
		send_frame(fb, 1'b0);
	endtask

	task automatic test_zero_cells();
		send_run(1'b1, 16'd0);
		send_run(1'b0, run_len(0));
		write_spb(8'd0);
		send_run(1'b1, 16'hFFFF);
		send_run(1'b0, 16'($urandom_range(65535)));
	endtask

	task automatic test_extreme_runs();
		write_spb(8'd255);
		send_run(1'b0, 16'hFFFF);
		write_spb(8'd1);
		send_run(1'b1, 16'hFFFF);
	endtask

	task automatic test_random(input int unsigned n, input logic [SPB_W-1:0] spb,
		input int unsigned tx, input int unsigned rx);
		int unsigned goal;
		tx_gap_pct = tx;
		rx_stall_pct = rx;
		write_spb(spb);
		goal = items_done + n;
		while (items_done < goal) begin
			if ($urandom_range(99) < 80) begin
				send_random_frame();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if (spb_cur >= 64 && $urandom_range(99) < 30)
						send_run(1'($urandom_range(1)), 16'($urandom_range(65535)));
					else
						send_run(1'($urandom_range(1)),
							16'($urandom_range(4 * spb_cur + 3)));
				end
			end
		end
	endtask

	// output held off long enough for a second record to stall the input
	task automatic test_backpressure();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		hold_req = 4000;
		repeat (5) send_random_frame();
		wait_drain();
		repeat (3) send_random_frame();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_short_history();
		test_check_ok_frame();
		test_zero_cells();
		test_extreme_runs();
		test_random(500, 8'd20, 12, 45);
		test_random(200, 8'd1, 12, 45);
		test_random(450, 8'd255, 45, 12);
		test_random(250, 8'($urandom_range(2, 254)), 45, 12);
		test_random(300, 8'd7, 0, 0);
		test_backpressure();
		settle();
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
